>>> design/ahlp_pkg.sv
// Shared types and constants for the alignment hit line parser.
`timescale 1ns / 1ps

package ahlp_pkg;

   // Parser phase, one-hot
   typedef enum logic [13:0] {
      PH_FIELD1   = 14'b00000000000001,
      PH_STRAND   = 14'b00000000000010,
      PH_FIELD2   = 14'b00000000000100,
      PH_C        = 14'b00000000001000,
      PH_H        = 14'b00000000010000,
      PH_R        = 14'b00000000100000,
      PH_ID       = 14'b00000001000000,
      PH_ONE      = 14'b00000010000000,
      PH_TWO      = 14'b00000100000000,
      PH_SEP      = 14'b00001000000000,
      PH_POS      = 14'b00010000000000,
      PH_HIT_ZERO = 14'b00100000000000,
      PH_HIT_POS  = 14'b01000000000000,
      PH_IGNORE   = 14'b10000000000000
   } phase_type;

   typedef enum logic [1:0] {
      ST_HIT      = 2'd0,
      ST_NO_CHROM = 2'd1,
      ST_FORMAT   = 2'd2
   } status_type;

   localparam logic [7:0] BYTE_TAB   = 8'd9;
   localparam logic [7:0] BYTE_NL    = 8'd10;
   localparam logic [7:0] CHAR_C     = 8'h63;
   localparam logic [7:0] CHAR_H     = 8'h68;
   localparam logic [7:0] CHAR_R     = 8'h72;
   localparam logic [7:0] CHAR_X     = 8'h58;
   localparam logic [7:0] CHAR_Y     = 8'h59;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_1     = 8'h31;
   localparam logic [7:0] CHAR_2     = 8'h32;
   localparam logic [7:0] CHAR_3     = 8'h33;
   localparam logic [7:0] CHAR_9     = 8'h39;

   localparam logic [4:0] CHROM_NONE = 5'd0;
   localparam logic [4:0] CHROM_TEN  = 5'd10;
   localparam logic [4:0] CHROM_TWENTY = 5'd20;
   localparam logic [4:0] CHROM_X    = 5'd24;
   localparam logic [4:0] CHROM_Y    = 5'd25;

   localparam logic [15:0] READ_LENGTH_RESET = 16'd50;
   localparam logic [31:0] POS_MAX           = 32'hFFFF_FFFF;

endpackage

>>> design/alignment_hit_line_parser_core.sv
// Byte-serial parser that reports one hit record per tab-separated text line.
`timescale 1ns / 1ps

// The result of a line is registered and valid in the cycle after the transfer of its newline byte.
// Throughput: one byte per cycle while req_stall is low; the single parser state register set is updated per byte.
// req_stall rises only while a finished result waits in the result register and rsp_stall is high.
// Reset (synchronous, active high): clears the parser state to the start of the first field,
// drops any pending result, and sets read_length back to 50.
module alignment_hit_line_parser_core (
   input  logic        clock,
   input  logic        reset,
   // byte input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_chromosome,
   output logic        rsp_minus_strand,
   output logic [31:0] rsp_position,
   // configuration
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   // ---------------------------------------------------------------
   // Line state
   // ---------------------------------------------------------------
   ahlp_pkg::phase_type phase_ff, phase_in;
   logic        minus_ff, minus_in;
   logic [4:0]  chrom_ff, chrom_in;
   logic [31:0] pos_acc_ff, pos_acc_in;
   logic        failed_ff, failed_in;

   logic [15:0] read_length_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_ff, status_in;
   logic [4:0]  rchrom_ff, rchrom_in;
   logic        rminus_ff, rminus_in;
   logic [31:0] rpos_ff, rpos_in;

   logic        byte_xfer;
   logic        line_end;
   logic [35:0] pos_times_ten;
   logic [32:0] pos_final;

   // Hold input bytes only while an unread result blocks the result register.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign byte_xfer = req_valid & ~req_stall;
   assign line_end  = byte_xfer && (req_char_in == ahlp_pkg::BYTE_NL);

   // pos*10 + digit, widened so overflow is visible for saturation
   assign pos_times_ten = {1'b0, pos_acc_ff, 3'b000} + {3'b000, pos_acc_ff, 1'b0}
                          + {32'd0, req_char_in[3:0]};

   // minus-strand read length add, saturated below
   assign pos_final = {1'b0, pos_acc_ff} + (minus_ff ? {17'd0, read_length_ff} : 33'd0);

   // ---------------------------------------------------------------
   // Per-byte phase update
   // ---------------------------------------------------------------
   always_comb begin
      phase_in   = phase_ff;
      minus_in   = minus_ff;
      chrom_in   = chrom_ff;
      pos_acc_in = pos_acc_ff;
      failed_in  = failed_ff;

      if (line_end) begin
         // newline: clear for the next line
         phase_in   = ahlp_pkg::PH_FIELD1;
         minus_in   = 1'b0;
         chrom_in   = ahlp_pkg::CHROM_NONE;
         pos_acc_in = '0;
         failed_in  = 1'b0;
      end else if (byte_xfer) begin
         case (phase_ff)
            ahlp_pkg::PH_FIELD1: begin
               if (req_char_in == ahlp_pkg::BYTE_TAB) phase_in = ahlp_pkg::PH_STRAND;
            end
            ahlp_pkg::PH_STRAND: begin
               if (req_char_in == ahlp_pkg::CHAR_PLUS || req_char_in == ahlp_pkg::CHAR_MINUS) begin
                  minus_in = (req_char_in == ahlp_pkg::CHAR_MINUS);
                  phase_in = ahlp_pkg::PH_FIELD2;
               end else begin
                  failed_in = 1'b1;
                  phase_in  = ahlp_pkg::PH_IGNORE;
               end
            end
            ahlp_pkg::PH_FIELD2: begin
               if (req_char_in == ahlp_pkg::BYTE_TAB) phase_in = ahlp_pkg::PH_C;
            end
            ahlp_pkg::PH_C: begin
               phase_in = (req_char_in == ahlp_pkg::CHAR_C) ? ahlp_pkg::PH_H
                                                            : ahlp_pkg::PH_IGNORE;
            end
            ahlp_pkg::PH_H: begin
               phase_in = (req_char_in == ahlp_pkg::CHAR_H) ? ahlp_pkg::PH_R
                                                            : ahlp_pkg::PH_IGNORE;
            end
            ahlp_pkg::PH_R: begin
               phase_in = (req_char_in == ahlp_pkg::CHAR_R) ? ahlp_pkg::PH_ID
                                                            : ahlp_pkg::PH_IGNORE;
            end
            ahlp_pkg::PH_ID: begin
               if (req_char_in == ahlp_pkg::CHAR_1) begin
                  chrom_in = 5'd1;
                  phase_in = ahlp_pkg::PH_ONE;
               end else if (req_char_in == ahlp_pkg::CHAR_2) begin
                  chrom_in = 5'd2;
                  phase_in = ahlp_pkg::PH_TWO;
               end else if (req_char_in inside {[ahlp_pkg::CHAR_3:ahlp_pkg::CHAR_9]}) begin
                  chrom_in = {1'b0, req_char_in[3:0]};
                  phase_in = ahlp_pkg::PH_SEP;
               end else if (req_char_in == ahlp_pkg::CHAR_X) begin
                  chrom_in = ahlp_pkg::CHROM_X;
                  phase_in = ahlp_pkg::PH_SEP;
               end else if (req_char_in == ahlp_pkg::CHAR_Y) begin
                  chrom_in = ahlp_pkg::CHROM_Y;
                  phase_in = ahlp_pkg::PH_SEP;
               end else begin
                  phase_in = ahlp_pkg::PH_IGNORE;
               end
            end
            ahlp_pkg::PH_ONE: begin
               // longest match: chr10..chr19
               if (req_char_in inside {[ahlp_pkg::CHAR_0:ahlp_pkg::CHAR_9]}) begin
                  chrom_in = ahlp_pkg::CHROM_TEN + {1'b0, req_char_in[3:0]};
                  phase_in = ahlp_pkg::PH_SEP;
               end else begin
                  phase_in = (req_char_in == ahlp_pkg::BYTE_TAB) ? ahlp_pkg::PH_POS
                                                                 : ahlp_pkg::PH_HIT_ZERO;
               end
            end
            ahlp_pkg::PH_TWO: begin
               // longest match: chr20..chr23
               if (req_char_in inside {[ahlp_pkg::CHAR_0:ahlp_pkg::CHAR_3]}) begin
                  chrom_in = ahlp_pkg::CHROM_TWENTY + {3'b000, req_char_in[1:0]};
                  phase_in = ahlp_pkg::PH_SEP;
               end else begin
                  phase_in = (req_char_in == ahlp_pkg::BYTE_TAB) ? ahlp_pkg::PH_POS
                                                                 : ahlp_pkg::PH_HIT_ZERO;
               end
            end
            ahlp_pkg::PH_SEP: begin
               phase_in = (req_char_in == ahlp_pkg::BYTE_TAB) ? ahlp_pkg::PH_POS
                                                              : ahlp_pkg::PH_HIT_ZERO;
            end
            ahlp_pkg::PH_POS: begin
               if (req_char_in inside {[ahlp_pkg::CHAR_0:ahlp_pkg::CHAR_9]}) begin
                  // saturate the decimal accumulation
                  pos_acc_in = (pos_times_ten[35:32] != 4'd0) ? ahlp_pkg::POS_MAX
                                                              : pos_times_ten[31:0];
               end else if (req_char_in == ahlp_pkg::BYTE_TAB) begin
                  phase_in = ahlp_pkg::PH_HIT_POS;
               end else begin
                  failed_in = 1'b1;
                  phase_in  = ahlp_pkg::PH_IGNORE;
               end
            end
            default: begin
               // hit decided or line dropped: ignore bytes until newline
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Result formation at newline
   // ---------------------------------------------------------------
   always_comb begin
      status_in = ahlp_pkg::ST_NO_CHROM;
      rchrom_in = ahlp_pkg::CHROM_NONE;
      rminus_in = 1'b0;
      rpos_in   = '0;

      if (failed_ff) begin
         status_in = ahlp_pkg::ST_FORMAT;
      end else begin
         case (phase_ff)
            ahlp_pkg::PH_FIELD1, ahlp_pkg::PH_STRAND, ahlp_pkg::PH_FIELD2,
            ahlp_pkg::PH_POS: begin
               status_in = ahlp_pkg::ST_FORMAT;
            end
            ahlp_pkg::PH_ONE, ahlp_pkg::PH_TWO, ahlp_pkg::PH_SEP,
            ahlp_pkg::PH_HIT_ZERO: begin
               // chromosome without a position field reports position zero
               status_in = ahlp_pkg::ST_HIT;
               rchrom_in = chrom_ff;
               rminus_in = minus_ff;
            end
            ahlp_pkg::PH_HIT_POS: begin
               status_in = ahlp_pkg::ST_HIT;
               rchrom_in = chrom_ff;
               rminus_in = minus_ff;
               rpos_in   = pos_final[32] ? ahlp_pkg::POS_MAX : pos_final[31:0];
            end
            default: begin
               status_in = ahlp_pkg::ST_NO_CHROM;
            end
         endcase
      end
   end

   // load on newline transfer, drop once taken downstream
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (line_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= ahlp_pkg::PH_FIELD1;
         minus_ff       <= 1'b0;
         chrom_ff       <= ahlp_pkg::CHROM_NONE;
         pos_acc_ff     <= '0;
         failed_ff      <= 1'b0;
         read_length_ff <= ahlp_pkg::READ_LENGTH_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         minus_ff     <= minus_in;
         chrom_ff     <= chrom_in;
         pos_acc_ff   <= pos_acc_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            read_length_ff <= csr_write_data;
         end
      end
   end

   // result payload: no reset needed
   always_ff @(posedge clock) begin
      if (line_end) begin
         status_ff <= status_in;
         rchrom_ff <= rchrom_in;
         rminus_ff <= rminus_in;
         rpos_ff   <= rpos_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_chromosome   = rchrom_ff;
   assign rsp_minus_strand = rminus_ff;
   assign rsp_position     = rpos_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_newline_gives_result: assert property (@(posedge clock) disable iff (reset)
      line_end |=> rsp_valid)
      else $error("newline transfer did not produce a result");

   a_non_hit_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ahlp_pkg::ST_HIT) |->
      (rsp_chromosome == ahlp_pkg::CHROM_NONE && !rsp_minus_strand && rsp_position == 32'd0))
      else $error("non-hit result carries hit fields");

   a_hit_has_chrom: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ahlp_pkg::ST_HIT) |->
      (rsp_chromosome != ahlp_pkg::CHROM_NONE && rsp_chromosome <= ahlp_pkg::CHROM_Y))
      else $error("hit result without a valid chromosome");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input not held while result is blocked");

endmodule
